// ===== src/dxt1rr_pkg.sv =====
// ----------------------------------------------------------------------------
// DXT1 rate reduction package
// Shared types, constants and threshold functions of the block.
// ----------------------------------------------------------------------------
package dxt1rr_pkg;

  localparam logic [31:0] PairLowMask = 32'h5555_5555;

  typedef enum logic [2:0] {
    MODE_SKIP  = 3'd0,
    MODE_SOLID = 3'd1,
    MODE_CLEAR = 3'd2,
    MODE_THREE = 3'd3,
    MODE_KEEP  = 3'd4
  } mode_e;

  typedef struct packed {
    logic [15:0] color_a;
    logic [15:0] color_b;
    logic [31:0] indices;
    mode_e       mode;
  } result_t;

  function automatic logic signed [9:0] max3(input logic signed [9:0] a,
                                             input logic signed [9:0] b,
                                             input logic signed [9:0] c);
    logic signed [9:0] m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [5:0] thr_solid(input logic [5:0] i);
    logic [5:0] t;
    if (i < 6'd4) begin
      t = 6'd12;
    end else if (i < 6'd11) begin
      t = 6'd6;
    end else begin
      t = 6'd3;
    end
    return t;
  endfunction

  function automatic logic [5:0] thr_clear(input logic [3:0] i);
    logic [5:0] t;
    if (i < 4'd2) begin
      t = 6'd12;
    end else if (i < 4'd3) begin
      t = 6'd6;
    end else begin
      t = 6'd3;
    end
    return t;
  endfunction

  function automatic logic [5:0] thr_three(input logic [3:0] i);
    logic [5:0] t;
    if (i < 4'd3) begin
      t = 6'd48;
    end else if (i < 4'd4) begin
      t = 6'd32;
    end else begin
      t = 6'd24;
    end
    return t;
  endfunction

endpackage

// ===== src/dxt1rr_eval.sv =====
// ----------------------------------------------------------------------------
// DXT1 rate reduction evaluator
// Combinational decision and rewrite of one block.
// ----------------------------------------------------------------------------
module dxt1rr_eval (
  input  logic [15:0]       color_a_i,
  input  logic [15:0]       color_b_i,
  input  logic [31:0]       indices_i,
  output dxt1rr_pkg::result_t result_o
);

  logic [7:0]        r0, g0, b0, r1, g1, b1;
  logic [7:0]        dr, dg, db;
  logic signed [9:0] chan1, delta1, chan23, delta23;
  logic [5:0]        thr1, thr2, thr3;
  logic [31:0]       hi, lo;
  logic [4:0]        avg_r, avg_b;
  logic [5:0]        avg_g;

  assign r0 = {color_a_i[15:11], color_a_i[15:13]};
  assign g0 = {color_a_i[10:5], color_a_i[10:9]};
  assign b0 = {color_a_i[4:0], color_a_i[4:2]};
  assign r1 = {color_b_i[15:11], color_b_i[15:13]};
  assign g1 = {color_b_i[10:5], color_b_i[10:9]};
  assign b1 = {color_b_i[4:0], color_b_i[4:2]};

  assign dr = dxt1rr_pkg::abs_diff(r0, r1);
  assign dg = dxt1rr_pkg::abs_diff(g0, g1);
  assign db = dxt1rr_pkg::abs_diff(b0, b1);

  assign chan1   = dxt1rr_pkg::max3($signed({2'b00, r0}) - 10'sd1, $signed({2'b00, g0}),
                                    $signed({2'b00, b0}) - 10'sd2);
  assign delta1  = dxt1rr_pkg::max3($signed({2'b00, dr}) - 10'sd1, $signed({2'b00, dg}),
                                    $signed({2'b00, db}) - 10'sd2);
  assign chan23  = dxt1rr_pkg::max3($signed({2'b00, r0}) - 10'sd2, $signed({2'b00, g0}),
                                    $signed({2'b00, b0}) - 10'sd5);
  assign delta23 = dxt1rr_pkg::max3($signed({2'b00, dr}) - 10'sd2, $signed({2'b00, dg}),
                                    $signed({2'b00, db}) - 10'sd5);

  assign thr1 = dxt1rr_pkg::thr_solid(chan1[7:2]);
  assign thr2 = dxt1rr_pkg::thr_clear(chan23[7:4]);
  assign thr3 = dxt1rr_pkg::thr_three(chan23[7:4]);

  assign avg_r = 5'(({1'b0, color_a_i[15:11]} + {1'b0, color_b_i[15:11]}) >> 1);
  assign avg_g = 6'(({1'b0, color_a_i[10:5]} + {1'b0, color_b_i[10:5]}) >> 1);
  assign avg_b = 5'(({1'b0, color_a_i[4:0]} + {1'b0, color_b_i[4:0]}) >> 1);

  assign hi = (indices_i >> 1) & dxt1rr_pkg::PairLowMask;
  assign lo = indices_i & dxt1rr_pkg::PairLowMask;

  always_comb begin
    result_o.color_a = color_a_i;
    result_o.color_b = color_b_i;
    result_o.indices = indices_i;
    result_o.mode    = dxt1rr_pkg::MODE_KEEP;
    if (indices_i == dxt1rr_pkg::PairLowMask) begin
      result_o.mode = dxt1rr_pkg::MODE_SKIP;
    end else if (delta1[7:0] <= {2'b00, thr1}) begin
      result_o.color_a = {avg_r, avg_g, avg_b};
      result_o.color_b = '0;
      result_o.indices = '0;
      result_o.mode    = dxt1rr_pkg::MODE_SOLID;
    end else if (delta23[7:0] <= {2'b00, thr2}) begin
      result_o.indices = lo;
      result_o.mode    = dxt1rr_pkg::MODE_CLEAR;
    end else if (delta23[7:0] <= {2'b00, thr3}) begin
      result_o.color_a = color_b_i;
      result_o.color_b = color_a_i;
      result_o.indices = (hi << 1) | (~hi & ~lo & dxt1rr_pkg::PairLowMask);
      result_o.mode    = dxt1rr_pkg::MODE_THREE;
    end
  end

endmodule

// ===== src/dxt1_block_rate_reduce.sv =====
// ----------------------------------------------------------------------------
// DXT1 block rate reduction
// Rewrites one DXT1 block per cycle into a form that compresses better.
//
//   Port group      Direction  Handshake
//   block input     in         start_i, taken when busy_o is low
//   block result    out        done_o, one-cycle strobe
//
// An item is registered at the edge where it is taken and its result is
// registered in the next cycle; done_o follows start_i via in_valid_q and done_q.
// One item may be taken in every cycle; busy_o stays low.
// Reset clears the valid flags of both register stages.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module dxt1_block_rate_reduce (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] end_color_a_i,
  input  logic [15:0] end_color_b_i,
  input  logic [31:0] texel_indices_i,
  input  logic        last_block_i,
  output logic        done_o,
  output logic [15:0] out_color_a_o,
  output logic [15:0] out_color_b_o,
  output logic [31:0] out_indices_o,
  output logic [2:0]  rewrite_mode_o,
  output logic        out_last_o
);

  logic                in_valid_q;
  logic [15:0]         color_a_q, color_b_q;
  logic [31:0]         indices_q;
  logic                last_q;
  dxt1rr_pkg::result_t res_d, res_q;
  logic                done_q, res_last_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      in_valid_q <= start_i && !busy_o;
      done_q     <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      color_a_q <= end_color_a_i;
      color_b_q <= end_color_b_i;
      indices_q <= texel_indices_i;
      last_q    <= last_block_i;
    end
    if (in_valid_q) begin
      res_q      <= res_d;
      res_last_q <= last_q;
    end
  end

  dxt1rr_eval u_eval (
    .color_a_i (color_a_q),
    .color_b_i (color_b_q),
    .indices_i (indices_q),
    .result_o  (res_d)
  );

  assign done_o         = done_q;
  assign out_color_a_o  = res_q.color_a;
  assign out_color_b_o  = res_q.color_b;
  assign out_indices_o  = res_q.indices;
  assign rewrite_mode_o = res_q.mode;
  assign out_last_o     = res_last_q;

endmodule
